// ===== src/logic_analyzer_trigger_capture_macros.svh =====
// assertion macros shared by the logic analyzer checker
`ifndef LOGIC_ANALYZER_TRIGGER_CAPTURE_MACROS_SVH
`define LOGIC_ANALYZER_TRIGGER_CAPTURE_MACROS_SVH

// checked only while out of reset
`define LATRG_ASSERT(lbl, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
    else $error("logic analyzer assertion failed");

// checked on every edge, reset included
`define LATRG_ASSERT_ALWAYS(lbl, prop) \
  lbl: assert property (@(posedge clk) (prop)) \
    else $error("logic analyzer assertion failed");

`endif

// ===== src/latrg_pkg.sv =====
// shared types and constants of the logic analyzer trigger and capture core
package latrg_pkg;

  localparam int DepthDefault    = 4096;
  localparam int ChannelsDefault = 8;

  localparam int CountW   = 13;
  localparam int PinW     = 8;
  localparam int IdxW     = 12;
  localparam int CfgIdxW  = 3;
  localparam int CfgDataW = 13;

  typedef enum logic [1:0] {
    ACT_TICK  = 2'd0,
    ACT_START = 2'd1,
    ACT_READ  = 2'd2,
    ACT_NONE  = 2'd3
  } action_t;

  typedef enum logic [1:0] {
    PH_IDLE    = 2'd0,
    PH_ARMED   = 2'd1,
    PH_CAPTURE = 2'd2,
    PH_DONE    = 2'd3
  } phase_t;

  typedef enum logic [CfgIdxW-1:0] {
    REG_SAMPLE_COUNT   = 3'd0,
    REG_PRESCALER      = 3'd1,
    REG_PERIOD         = 3'd2,
    REG_TRIGGER_ENABLE = 3'd3,
    REG_LEVEL_MASK     = 3'd4,
    REG_LEVEL_VALUE    = 3'd5,
    REG_RISING_MASK    = 3'd6,
    REG_FALLING_MASK   = 3'd7
  } reg_idx_t;

  typedef struct packed {
    logic [CountW-1:0] sample_count;
    logic [7:0]        prescaler;
    logic [7:0]        period;
    logic              trigger_enable;
    logic [PinW-1:0]   level_mask;
    logic [PinW-1:0]   level_value;
    logic [PinW-1:0]   rising_mask;
    logic [PinW-1:0]   falling_mask;
  } cfg_t;

  localparam cfg_t CfgRst = '{
    sample_count:   13'd4096,
    prescaler:      8'd0,
    period:         8'd1,
    trigger_enable: 1'b0,
    level_mask:     8'd0,
    level_value:    8'd0,
    rising_mask:    8'd0,
    falling_mask:   8'd0
  };

  // one classified item as it waits between front and back
  typedef struct packed {
    action_t         action;
    logic [PinW-1:0] pins;
    logic [IdxW-1:0] read_index;
    logic            trig;
  } item_t;

endpackage

// ===== src/latrg_ram.sv =====
// generic single write port ram with registered read
module latrg_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 4096
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem_r[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

// ===== src/latrg_front.sv =====
// front end: accepts items, tracks pin history, evaluates the trigger, queues items
module latrg_front #(
  parameter int CHANNELS = latrg_pkg::ChannelsDefault
) (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      in_valid,
  output logic                      in_ready,
  input  logic [1:0]                in_action,
  input  logic [latrg_pkg::PinW-1:0] in_pins,
  input  logic [latrg_pkg::IdxW-1:0] in_read_index,
  input  latrg_pkg::cfg_t           cfg,
  output logic                      q_valid,
  output latrg_pkg::item_t          q_item,
  input  logic                      q_pop
);
  import latrg_pkg::*;

  localparam logic [PinW-1:0] ChanMask = PinW'((32'd1 << CHANNELS) - 32'd1);

  logic [PinW-1:0] prev_pins_r, prev_pins_nxt;
  logic [PinW-1:0] pins_m, rose, fell, edges, hit, lm;
  logic            trig;
  logic            push;
  item_t           item;

  item_t      q_mem_r [2];
  logic       wr_ptr_r, wr_ptr_nxt;
  logic       rd_ptr_r, rd_ptr_nxt;
  logic [1:0] cnt_r, cnt_nxt;

  // trigger condition against the pins of the previous tick
  always_comb begin
    pins_m = in_pins & ChanMask;
    rose   = ~prev_pins_r & pins_m;
    fell   = prev_pins_r & ~pins_m;
    edges  = (cfg.rising_mask | cfg.falling_mask) & ChanMask;
    hit    = (cfg.rising_mask & rose) | (cfg.falling_mask & fell);
    lm     = cfg.level_mask & ChanMask;
    trig   = ((hit & edges) == edges) && ((pins_m & lm) == (cfg.level_value & lm));

    item.action     = action_t'(in_action);
    item.pins       = pins_m;
    item.read_index = in_read_index;
    item.trig       = trig;
  end

  assign in_ready = (cnt_r != 2'd2);
  assign push     = in_valid && in_ready;
  assign q_valid  = (cnt_r != 2'd0);
  assign q_item   = q_mem_r[rd_ptr_r];

  always_comb begin
    prev_pins_nxt = prev_pins_r;
    if (push && (action_t'(in_action) == ACT_TICK)) begin
      prev_pins_nxt = pins_m;
    end
    wr_ptr_nxt = push ? ~wr_ptr_r : wr_ptr_r;
    rd_ptr_nxt = q_pop ? ~rd_ptr_r : rd_ptr_r;
    cnt_nxt    = cnt_r + {1'b0, push} - {1'b0, q_pop};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      prev_pins_r <= '0;
      wr_ptr_r    <= 1'b0;
      rd_ptr_r    <= 1'b0;
      cnt_r       <= '0;
    end else begin
      prev_pins_r <= prev_pins_nxt;
      wr_ptr_r    <= wr_ptr_nxt;
      rd_ptr_r    <= rd_ptr_nxt;
      cnt_r       <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      q_mem_r[wr_ptr_r] <= item;
    end
  end

endmodule

// ===== src/latrg_back.sv =====
// back end: capture state machine, sample buffer and result register
module latrg_back #(
  parameter int DEPTH = latrg_pkg::DepthDefault
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         q_valid,
  input  latrg_pkg::item_t             q_item,
  output logic                         q_pop,
  input  latrg_pkg::cfg_t              cfg,
  output logic                         out_valid,
  input  logic                         out_ready,
  output logic [1:0]                   out_phase,
  output logic [latrg_pkg::CountW-1:0] out_captured,
  output logic [latrg_pkg::PinW-1:0]   out_read_data
);
  import latrg_pkg::*;

  localparam int AW = $clog2(DEPTH);

  phase_t            phase_r, phase_nxt;
  logic [CountW-1:0] wi_r, wi_nxt;
  logic [7:0]        pc_r, pc_nxt;
  logic [7:0]        perc_r, perc_nxt;
  logic [CountW-1:0] lim;
  logic              exec;
  logic              we, re, hit;

  logic              out_valid_r, out_valid_nxt;
  phase_t            out_phase_r;
  logic [CountW-1:0] out_captured_r;
  logic              hit_r;
  logic [PinW-1:0]   ram_q;

  assign lim   = (32'(cfg.sample_count) > DEPTH) ? CountW'(DEPTH) : cfg.sample_count;
  assign exec  = q_valid && (!out_valid_r || out_ready);
  assign q_pop = exec;

  always_comb begin
    phase_nxt = phase_r;
    wi_nxt    = wi_r;
    pc_nxt    = pc_r;
    perc_nxt  = perc_r;
    we        = 1'b0;
    re        = 1'b0;
    hit       = 1'b0;
    if (exec) begin
      unique case (q_item.action)
        ACT_TICK: begin
          if (phase_r == PH_ARMED) begin
            if (q_item.trig) begin
              phase_nxt = PH_CAPTURE;
              pc_nxt    = '0;
              perc_nxt  = '0;
            end
          end else if (phase_r == PH_CAPTURE) begin
            if (pc_r >= cfg.prescaler) begin
              pc_nxt = '0;
              if (perc_r == '0) begin
                // sample point
                perc_nxt = cfg.period;
                if (wi_r < lim) begin
                  we     = 1'b1;
                  wi_nxt = wi_r + 1'b1;
                end
                if (wi_nxt >= lim) begin
                  phase_nxt = PH_DONE;
                end
              end else begin
                perc_nxt = perc_r - 1'b1;
              end
            end else begin
              pc_nxt = pc_r + 1'b1;
            end
          end
        end
        ACT_START: begin
          wi_nxt   = '0;
          pc_nxt   = '0;
          perc_nxt = '0;
          if (lim == '0) begin
            phase_nxt = PH_DONE;
          end else if (cfg.trigger_enable) begin
            phase_nxt = PH_ARMED;
          end else begin
            phase_nxt = PH_CAPTURE;
          end
        end
        ACT_READ: begin
          re  = 1'b1;
          hit = ({1'b0, q_item.read_index} < wi_r) && (32'(q_item.read_index) < DEPTH);
        end
        ACT_NONE: begin
        end
        default: begin
        end
      endcase
    end

    out_valid_nxt = out_valid_r;
    if (exec) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r     <= PH_IDLE;
      wi_r        <= '0;
      pc_r        <= '0;
      perc_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      phase_r     <= phase_nxt;
      wi_r        <= wi_nxt;
      pc_r        <= pc_nxt;
      perc_r      <= perc_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // result payload, loaded together with the ram read data
  always_ff @(posedge clk) begin
    if (exec) begin
      out_phase_r    <= phase_nxt;
      out_captured_r <= wi_nxt;
      hit_r          <= hit;
    end
  end

  latrg_ram #(
    .WIDTH (PinW),
    .DEPTH (DEPTH)
  ) u_ram (
    .clk   (clk),
    .we    (we),
    .waddr (AW'(wi_r)),
    .wdata (q_item.pins),
    .re    (re),
    .raddr (AW'(q_item.read_index)),
    .rdata (ram_q)
  );

  assign out_valid     = out_valid_r;
  assign out_phase     = out_phase_r;
  assign out_captured  = out_captured_r;
  assign out_read_data = hit_r ? ram_q : '0;

endmodule

// ===== src/logic_analyzer_trigger_capture.sv =====
// Logic analyzer trigger and capture core. Takes one item (tick, start or read) every clock
// while results are being taken; an item waits in the queue, then its result is registered.
// A two-entry queue between the trigger front end and the capture back end, plus the result
// register, absorbs output stalls. The sample buffer is a DEPTH-byte ram with one write
// port and a registered read port; it has no clearing pass, since only captured positions
// are read. Configuration registers are written through cfg_we/cfg_index/cfg_wdata;
// the user must write them only while the core is idle; the core does not enforce this.
module logic_analyzer_trigger_capture #(
  parameter int DEPTH    = latrg_pkg::DepthDefault,
  parameter int CHANNELS = latrg_pkg::ChannelsDefault
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_valid,
  output logic                           in_ready,
  input  logic [1:0]                     in_action,
  input  logic [latrg_pkg::PinW-1:0]     in_pins,
  input  logic [latrg_pkg::IdxW-1:0]     in_read_index,
  output logic                           out_valid,
  input  logic                           out_ready,
  output logic [1:0]                     out_phase,
  output logic [latrg_pkg::CountW-1:0]   out_captured,
  output logic [latrg_pkg::PinW-1:0]     out_read_data,
  input  logic                           cfg_we,
  input  logic [latrg_pkg::CfgIdxW-1:0]  cfg_index,
  input  logic [latrg_pkg::CfgDataW-1:0] cfg_wdata
);
  import latrg_pkg::*;

  cfg_t  cfg_r, cfg_nxt;
  logic  q_valid, q_pop;
  item_t q_item;

  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_we) begin
      unique case (reg_idx_t'(cfg_index))
        REG_SAMPLE_COUNT:   cfg_nxt.sample_count   = cfg_wdata;
        REG_PRESCALER:      cfg_nxt.prescaler      = cfg_wdata[7:0];
        REG_PERIOD:         cfg_nxt.period         = cfg_wdata[7:0];
        REG_TRIGGER_ENABLE: cfg_nxt.trigger_enable = cfg_wdata[0];
        REG_LEVEL_MASK:     cfg_nxt.level_mask     = cfg_wdata[PinW-1:0];
        REG_LEVEL_VALUE:    cfg_nxt.level_value    = cfg_wdata[PinW-1:0];
        REG_RISING_MASK:    cfg_nxt.rising_mask    = cfg_wdata[PinW-1:0];
        REG_FALLING_MASK:   cfg_nxt.falling_mask   = cfg_wdata[PinW-1:0];
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r <= CfgRst;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  latrg_front #(
    .CHANNELS (CHANNELS)
  ) u_front (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_valid),
    .in_ready      (in_ready),
    .in_action     (in_action),
    .in_pins       (in_pins),
    .in_read_index (in_read_index),
    .cfg           (cfg_r),
    .q_valid       (q_valid),
    .q_item        (q_item),
    .q_pop         (q_pop)
  );

  latrg_back #(
    .DEPTH (DEPTH)
  ) u_back (
    .clk           (clk),
    .rst_n         (rst_n),
    .q_valid       (q_valid),
    .q_item        (q_item),
    .q_pop         (q_pop),
    .cfg           (cfg_r),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .out_phase     (out_phase),
    .out_captured  (out_captured),
    .out_read_data (out_read_data)
  );

endmodule

// ===== src/latrg_checker.sv =====
// port-level checks for the logic analyzer core, bound to the top level
`include "logic_analyzer_trigger_capture_macros.svh"

module latrg_checker #(
  parameter int DEPTH = latrg_pkg::DepthDefault
) (
  input logic                         clk,
  input logic                         rst_n,
  input logic                         out_valid,
  input logic                         out_ready,
  input logic [1:0]                   out_phase,
  input logic [latrg_pkg::CountW-1:0] out_captured,
  input logic [latrg_pkg::PinW-1:0]   out_read_data
);
  import latrg_pkg::*;

  // no stale result survives reset
  `LATRG_ASSERT_ALWAYS(a_no_result_after_reset, !rst_n |=> !out_valid)

  // a stalled result keeps its contents
  `LATRG_ASSERT(a_result_holds, out_valid && !out_ready |=> out_valid && $stable(out_phase) && $stable(out_captured) && $stable(out_read_data))

  // before the first start nothing is captured and reads give zero
  `LATRG_ASSERT(a_idle_empty, out_valid && out_phase == PH_IDLE |-> out_captured == '0 && out_read_data == '0)

  // the capture never runs past the buffer
  `LATRG_ASSERT(a_captured_bound, out_valid |-> 32'(out_captured) <= DEPTH)

endmodule

bind logic_analyzer_trigger_capture latrg_checker #(
  .DEPTH (DEPTH)
) u_latrg_checker (
  .clk           (clk),
  .rst_n         (rst_n),
  .out_valid     (out_valid),
  .out_ready     (out_ready),
  .out_phase     (out_phase),
  .out_captured  (out_captured),
  .out_read_data (out_read_data)
);
